[rtl/core/dcrd_pkg.sv]
// ----------------------------------------------------------------------------
// dcrd_pkg
// Types and constants shared by the distance code ring decoder.
// ----------------------------------------------------------------------------
package dcrd_pkg;

   localparam int RingDepth = 4;
   localparam int RingIdxW  = $clog2(RingDepth);

   localparam logic [31:0] RingReset [RingDepth] = '{32'd4, 32'd11, 32'd15, 32'd16};

   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 7;

   localparam logic [CsrIndexW-1:0] CsrSpecialEnable = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrDirectCount   = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrPostfixBits   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // one classified item waiting for the back end
   typedef struct packed {
      logic                reuse;   // ring reuse code
      logic [RingIdxW-1:0] back;    // slots back from write position, mod depth
      logic [1:0]          delta;
      logic                add;
      logic                push;    // result goes into the ring on success
      logic [31:0]         base;
      logic [1:0]          shamt;
      logic [7:0]          addend;
      logic [8:0]          nbits;
   } dcrd_entry_type;

endpackage

[rtl/core/dcrd_front.sv]
// ----------------------------------------------------------------------------
// dcrd_front
// Accepts distance codes, classifies them and precomputes the ring-free part.
// ----------------------------------------------------------------------------
module dcrd_front (
   input  logic                    special_enable,
   input  logic [6:0]              direct_count,
   input  logic [1:0]              postfix_bits,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [9:0]              distance_code,
   input  logic [23:0]             extra_value,
   input  logic                    q_full,
   output logic                    q_push,
   output dcrd_pkg::dcrd_entry_type q_entry
);
   import dcrd_pkg::*;

   logic [4:0]  special;
   logic [7:0]  first_formula;
   logic        in_formula;
   logic        is_reuse;
   logic        is_direct;
   logic [9:0]  x;
   logic [9:0]  nbits_full;
   logic [9:0]  high;
   logic [2:0]  low;
   logic [31:0] lead;
   logic [3:0]  c;
   logic [3:0]  k;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      special       = special_enable ? 5'd16 : 5'd0;
      first_formula = {1'b0, direct_count} + {3'd0, special};
      in_formula    = distance_code >= {2'd0, first_formula};
      is_reuse      = special_enable && (distance_code < 10'd16);
      is_direct     = !is_reuse && !in_formula;
      x             = distance_code - {2'd0, first_formula};
      nbits_full    = (x >> ({1'b0, postfix_bits} + 3'd1)) + 10'd1;
      high          = x >> postfix_bits;
      low           = x[2:0] & ~(3'b111 << postfix_bits);
      lead          = (nbits_full >= 10'd32) ? 32'd0
                    : ({30'd0, 1'b1, high[0]} << nbits_full[4:0]);
      c             = distance_code[3:0];
      k             = (c >= 4'd10) ? c - 4'd10 : c - 4'd4;

      q_entry = '0;
      q_entry.reuse = is_reuse;
      q_entry.push  = !is_reuse || (c != 4'd0);

      if (c == 4'd2) begin
         q_entry.back = 2'd3;
      end else if (c == 4'd3) begin
         q_entry.back = 2'd0;
      end else if (c == 4'd1 || c >= 4'd10) begin
         q_entry.back = 2'd2;
      end else begin
         q_entry.back = 2'd1;
      end

      if (c >= 4'd4) begin
         q_entry.delta = k[2:1] + 2'd1;
         q_entry.add   = k[0];
      end

      if (in_formula) begin
         q_entry.nbits  = nbits_full[9] ? 9'd511 : nbits_full[8:0];
         q_entry.base   = lead + {8'd0, extra_value} - 32'd4;
         q_entry.shamt  = postfix_bits;
         q_entry.addend = {5'd0, low} + {1'b0, direct_count} + 8'd1;
      end else if (is_direct) begin
         q_entry.base = {22'd0, distance_code} - {27'd0, special} + 32'd1;
      end
   end

endmodule

[rtl/core/dcrd_queue.sv]
// ----------------------------------------------------------------------------
// dcrd_queue
// Short queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module dcrd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dcrd_pkg::dcrd_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output dcrd_pkg::dcrd_entry_type head_entry
);
   import dcrd_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   dcrd_entry_type       slot_ff [DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign full       = count_ff == CntW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/dcrd_back.sv]
// ----------------------------------------------------------------------------
// dcrd_back
// Resolves ring reuse codes, updates the ring and holds the result register.
// ----------------------------------------------------------------------------
module dcrd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  dcrd_pkg::dcrd_entry_type q_entry,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_distance,
   output dcrd_pkg::status_type    rsp_status,
   output logic [8:0]              rsp_nbits
);
   import dcrd_pkg::*;

   logic [31:0]         ring_ff [RingDepth];
   logic [RingIdxW-1:0] pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         distance_ff;
   status_type          status_ff;
   logic [8:0]          nbits_ff;

   logic [RingIdxW-1:0] rd_idx;
   logic [31:0]         rd;
   logic [32:0]         sum;
   logic [31:0]         lin;
   logic [31:0]         dist_val;
   status_type          status;
   logic                take;
   logic                push_ok;

   always_comb begin
      rd_idx   = pos_ff - q_entry.back;
      rd       = ring_ff[rd_idx];
      sum      = {1'b0, rd} + {31'd0, q_entry.delta};
      lin      = (q_entry.base << q_entry.shamt) + {24'd0, q_entry.addend};
      dist_val = lin;
      status   = STATUS_OK;
      if (q_entry.reuse) begin
         dist_val = rd;
         if (q_entry.delta != 2'd0) begin
            if (q_entry.add) begin
               if (sum >= 33'h0_FFFF_FFFF) begin
                  dist_val = 32'd0;
                  status   = STATUS_OVERFLOW;
               end else begin
                  dist_val = sum[31:0];
               end
            end else begin
               if (rd <= {30'd0, q_entry.delta}) begin
                  dist_val = 32'd0;
                  status   = STATUS_UNDERFLOW;
               end else begin
                  dist_val = rd - {30'd0, q_entry.delta};
               end
            end
         end
      end
      take         = q_valid && (!rsp_valid_ff || rsp_tready);
      push_ok      = take && q_entry.push && (status == STATUS_OK);
      pos_in       = push_ok ? pos_ff + 1'b1 : pos_ff;
      rsp_valid_in = take || (rsp_valid_ff && !rsp_tready);
   end

   assign q_pop        = take;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_distance = distance_ff;
   assign rsp_status   = status_ff;
   assign rsp_nbits    = nbits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RingDepth; i++) begin
            ring_ff[i] <= RingReset[i];
         end
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push_ok) begin
            ring_ff[pos_ff] <= dist_val;
         end
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         distance_ff <= dist_val;
         status_ff   <= status;
         nbits_ff    <= q_entry.nbits;
      end
   end

endmodule

[rtl/core/distance_code_ring_decoder_core.sv]
// ----------------------------------------------------------------------------
// distance_code_ring_decoder_core
// Decodes distance codes with a ring of the last four distances.
//
// channel  dir  tdata (low bit up)                            handshake
// req      in   distance_code[9:0], extra_value[33:10]        req_tvalid/tready
// rsp      out  distance[31:0], status[33:32], nbits[42:34]   rsp_tvalid/tready
// csr      in   index 0 special_enable, 1 direct_count, 2 postfix_bits; csr_we
//
// One transaction per cycle sustained while rsp_tready stays high; rsp_tvalid
// rises once the accepted req item has passed the queue slot and the result
// register. The ring read, adjust and write-back of the back end set that pace.
// Reset is synchronous; the ring reloads 4, 11, 15, 16 at once.
// A two-entry queue absorbs a stalled rsp side; req_tready falls when it fills.
// ----------------------------------------------------------------------------
module distance_code_ring_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0]                       req_tdata,  // distance_code, extra_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,  // distance, status, extra_bit_count
   input  logic                              csr_we,
   input  logic [dcrd_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [dcrd_pkg::CsrDataW-1:0]     csr_wdata
);
   import dcrd_pkg::*;

   logic           special_enable_ff;
   logic [6:0]     direct_count_ff;
   logic [1:0]     postfix_bits_ff;

   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_valid;
   dcrd_entry_type front_entry;
   dcrd_entry_type head_entry;

   logic [31:0]    rsp_distance;
   status_type     rsp_status;
   logic [8:0]     rsp_nbits;

   always_ff @(posedge clock) begin
      if (reset) begin
         special_enable_ff <= 1'b1;
         direct_count_ff   <= 7'd0;
         postfix_bits_ff   <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            CsrSpecialEnable: special_enable_ff <= csr_wdata[0];
            CsrDirectCount:   direct_count_ff   <= csr_wdata[6:0];
            CsrPostfixBits:   postfix_bits_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   dcrd_front u_front (
      .special_enable (special_enable_ff),
      .direct_count   (direct_count_ff),
      .postfix_bits   (postfix_bits_ff),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .distance_code  (req_tdata[9:0]),
      .extra_value    (req_tdata[33:10]),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (front_entry)
   );

   dcrd_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   dcrd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (head_entry),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_distance (rsp_distance),
      .rsp_status   (rsp_status),
      .rsp_nbits    (rsp_nbits)
   );

   assign rsp_tdata = {5'd0, rsp_nbits, rsp_status, rsp_distance};

endmodule

[rtl/core/dcrd_checker.sv]
// ----------------------------------------------------------------------------
// dcrd_checker
// Port-level checks on the distance code ring decoder.
// ----------------------------------------------------------------------------
module dcrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != 2'd0 |-> rsp_tdata[31:0] == 32'd0)
      else $error("error status with nonzero distance");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3 && rsp_tdata[47:43] == 5'd0)
      else $error("bad status code or padding");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not empty after reset");

endmodule

bind distance_code_ring_decoder_core dcrd_checker u_dcrd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/distance_code_ring_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_code_ring_checker
// Watches the req, rsp and csr ports of the distance code ring decoder, keeps
// its own copy of the distance ring and registers, predicts the result of
// each accepted req transaction and compares every rsp transaction with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module distance_code_ring_checker
   import dcrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [39:0]          req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [47:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   output int                   error_count,
   output int                   pending
);

   typedef struct packed {
      logic [31:0] distance;
      status_type  status;
      logic [8:0]  nbits;
   } decoded_type;

   logic [31:0]         ring [RingDepth];
   logic [RingIdxW-1:0] wr_pos;
   logic                special_en;
   logic [6:0]          direct_cnt;
   logic [1:0]          postfix;
   decoded_type         expected_results [$];
   decoded_type         want;

   initial begin
      error_count = 0;
      pending     = 0;
   end

   function automatic logic [31:0] shift_or_zero(logic [31:0] v, int unsigned n);
      return (n >= 32) ? 32'd0 : (v << n);
   endfunction

   function automatic void push_ring(logic [31:0] v);
      ring[wr_pos] = v;
      wr_pos       = wr_pos + 1'b1;
   endfunction

   function automatic decoded_type decode_distance(logic [9:0] code, logic [23:0] extra);
      int unsigned special, first_code, nbits, back, delta, k, x, high, low;
      logic [31:0] offset, dist_val;
      logic        add_delta;
      status_type  st;
      decoded_type res;
      special    = special_en ? 16 : 0;
      first_code = direct_cnt + special;
      nbits      = 0;
      dist_val   = '0;
      st         = STATUS_OK;
      if (code >= first_code) nbits = 1 + ((code - first_code) >> (postfix + 1));
      if (code < special) begin
         if (code == 2) back = 3;
         else if (code == 3) back = 4;
         else if (code == 1 || code >= 10) back = 2;
         else back = 1;
         dist_val  = ring[RingIdxW'((wr_pos + RingDepth - back) % RingDepth)];
         delta     = 0;
         add_delta = 1'b0;
         if (code >= 4) begin
            k         = (code >= 10) ? code - 10 : code - 4;
            delta     = (k >> 1) + 1;
            add_delta = (k & 1) != 0;
         end
         if (delta != 0) begin
            if (add_delta) begin
               if (dist_val < 32'hFFFF_FFFF - delta) dist_val = dist_val + delta;
               else begin
                  dist_val = '0;
                  st       = STATUS_OVERFLOW;
               end
            end else begin
               if (dist_val > delta) dist_val = dist_val - delta;
               else begin
                  dist_val = '0;
                  st       = STATUS_UNDERFLOW;
               end
            end
         end
         if (st == STATUS_OK && code != 0) push_ring(dist_val);
      end else if (code < first_code) begin
         dist_val = code - special + 1;
         push_ring(dist_val);
      end else begin
         x        = code - first_code;
         high     = x >> postfix;
         low      = x & ((1 << postfix) - 1);
         offset   = shift_or_zero(2 | (high & 1), nbits) - 32'd4;
         dist_val = shift_or_zero(offset + extra, postfix) + low + direct_cnt + 1;
         push_ring(dist_val);
      end
      res.distance = dist_val;
      res.status   = st;
      res.nbits    = (nbits > 511) ? 9'd511 : nbits[8:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RingDepth; i++) ring[i] = RingReset[i];
         wr_pos     = '0;
         special_en = 1'b1;
         direct_cnt = '0;
         postfix    = '0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrSpecialEnable: special_en = csr_wdata[0];
               CsrDirectCount:   direct_cnt = csr_wdata[6:0];
               CsrPostfixBits:   postfix    = csr_wdata[1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(decode_distance(req_tdata[9:0], req_tdata[33:10]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected transaction: distance %0d, status %0d, nbits %0d",
                      rsp_tdata[31:0], rsp_tdata[33:32], rsp_tdata[42:34]);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.distance) begin
                  $error("distance mismatch: expected %0d, actual %0d",
                         want.distance, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[33:32] !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_tdata[33:32]);
                  error_count++;
               end
               if (rsp_tdata[42:34] !== want.nbits) begin
                  $error("extra_bit_count mismatch: expected %0d, actual %0d",
                         want.nbits, rsp_tdata[42:34]);
                  error_count++;
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

[sim/distance_code_ring_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_code_ring_decoder_core_tb
// Drives distance codes into the decoder: a directed set covering the reuse
// codes, ring underflow and overflow, huge shifts and count saturation, then
// random phases under several register settings with random idling on both
// channels and one long rsp stall. The checker does the prediction.
// ----------------------------------------------------------------------------
module distance_code_ring_decoder_core_tb;
   import dcrd_pkg::*;

   localparam int NumItems       = 950;
   localparam int NumPhases      = 10;
   localparam int WatchdogLimit  = 4000;
   localparam int SinkHoldCycles = 300;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata  = '0;   // distance_code[9:0], extra_value[33:10]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [47:0]          rsp_tdata;         // distance[31:0], status[33:32], nbits[42:34]
   logic                 csr_we     = 1'b0;
   logic [CsrIndexW-1:0] csr_index  = '0;
   logic [CsrDataW-1:0]  csr_wdata  = '0;

   int error_count;
   int pending;
   int quiet_cycles = 0;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   bit sink_hold = 1'b0;

   logic        special_on  = 1'b1;
   int unsigned direct_num  = 0;
   int unsigned postfix_num = 0;

   always #5 clock = ~clock;

   distance_code_ring_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   distance_code_ring_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_code(logic [9:0] code, logic [23:0] extra);
      int gap;
      gap = pick_gap(src_idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, extra, code};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // writes all three registers; upper bits of the narrow ones carry noise
   task automatic apply_config(logic se, logic [6:0] dc, logic [1:0] pb);
      csr_we     <= 1'b1;
      csr_index  <= CsrSpecialEnable;
      csr_wdata  <= {6'($urandom), se};
      @(negedge clock);
      csr_index  <= CsrDirectCount;
      csr_wdata  <= dc;
      @(negedge clock);
      csr_index  <= CsrPostfixBits;
      csr_wdata  <= {5'($urandom), pb};
      @(negedge clock);
      csr_we      <= 1'b0;
      special_on  = se;
      direct_num  = 32'(dc);
      postfix_num = 32'(pb);
   endtask

   task automatic pick_item(output logic [9:0] code, output logic [23:0] extra);
      int unsigned special, first_code, r, r2;
      special    = special_on ? 16 : 0;
      first_code = direct_num + special;
      r          = $urandom_range(0, 99);
      if (r < 35 && special_on) code = 10'($urandom_range(0, 15));
      else if (r < 50 && direct_num > 0)
         code = 10'(special + $urandom_range(0, direct_num - 1));
      else if (r < 62) code = 10'($urandom_range(0, 1023));
      else if (r < 72) code = 10'(first_code + $urandom_range(0, 3));
      else if (r < 80)
         code = 10'(first_code + (($urandom_range(28, 32) - 1) << (postfix_num + 1))
                    + $urandom_range(0, (2 << postfix_num) - 1));
      else code = 10'(first_code + $urandom_range(0, 63));
      r2 = $urandom_range(0, 99);
      if (r >= 62 && r < 72) extra = 24'($urandom_range(0, 3));
      else if (r2 < 15) extra = '0;
      else if (r2 < 25) extra = 24'hFF_FFFF;
      else if (r2 < 45) extra = 24'($urandom_range(0, 15));
      else extra = 24'($urandom);
   endtask

   always @(posedge clock) begin
      if (reset) quiet_cycles <= 0;
      else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WatchdogLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (sink_hold) begin
            rsp_tready <= 1'b0;
            repeat (SinkHoldCycles) @(negedge clock);
            sink_hold = 1'b0;
         end
         stall = pick_gap(sink_idle_pct);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [9:0]  code;
      logic [23:0] extra;
      logic        se;
      logic [6:0]  dc;
      logic [1:0]  pb;
      int          per_phase;
      per_phase = NumItems / NumPhases;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: reuse codes on, no direct codes, no postfix
      for (int c = 0; c < 16; c++) send_code(10'(c), 24'($urandom));
      send_code(10'd16, 24'd0);        // pushes distance 1
      send_code(10'd4, 24'd0);         // last minus one: underflow
      send_code(10'd78, 24'd1);        // shift past 32 bits, pushes 0xFFFFFFFE
      send_code(10'd5, 24'd0);         // last plus one: overflow
      send_code(10'd1023, 24'hFF_FFFF);
      send_code(10'd16, 24'hFF_FFFF);
      wait_for_results();
      apply_config(1'b0, 7'd0, 2'd0);
      send_code(10'd1023, 24'hFF_FFFF); // count of 512 saturates
      send_code(10'd0, 24'd0);
      wait_for_results();
      apply_config(1'b1, 7'd127, 2'd3);
      send_code(10'd142, 24'd0);         // last direct code above 120
      send_code(10'd143, 24'hFF_FFFF);

      for (int p = 0; p < NumPhases; p++) begin
         wait_for_results();
         case (p)
            0: begin se = 1'b1; dc = 7'd0;   pb = 2'd0; end
            1: begin se = 1'b0; dc = 7'd0;   pb = 2'd0; end
            2: begin se = 1'b1; dc = 7'd120; pb = 2'd3; end
            3: begin se = 1'b0; dc = 7'd127; pb = 2'd3; end
            4: begin se = 1'b1; dc = 7'd5;   pb = 2'd1; end
            5: begin se = 1'b0; dc = 7'd64;  pb = 2'd2; end
            default: begin
               se = 1'($urandom_range(0, 1));
               dc = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 12));
               pb = 2'($urandom_range(0, 3));
            end
         endcase
         apply_config(se, dc, pb);
         src_idle_pct  = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 50);
         sink_idle_pct = ((p + 1) % 3 == 0) ? 0 : (((p + 1) % 3 == 1) ? 25 : 50);
         for (int n = 0; n < per_phase; n++) begin
            if (p == 2 && n == 10) sink_hold = 1'b1;
            if (p == 4 && n == 40) wait_for_results();
            pick_item(code, extra);
            send_code(code, extra);
         end
      end

      wait_for_results();
      repeat (4) @(negedge clock);
      if (error_count == 0 && pending == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
